// File: rtl/atpd_pkg.sv
// ----------------------------------------------------------------------------
// atpd_pkg
// Shared constants and types of the adaptive threshold peak detector:
// register indexes, reset values and the controller/datapath interface.
// ----------------------------------------------------------------------------
package atpd_pkg;

   // default parameter values
   localparam int MAX_LOG_BLOCK_DEF = 10;
   localparam int SAMPLE_BITS_DEF   = 16;
   localparam int POSITION_BITS_DEF = 32;

   // register field widths
   localparam int LOG_FIELD_BITS = 4;
   localparam int GAIN_BITS      = 8;
   localparam int LAG_BITS       = 10;
   localparam int CSR_ADDR_BITS  = 2;
   localparam int CSR_DATA_BITS  = 10;

   // limit width and saturation value
   localparam int LIMIT_BITS = 24;
   localparam logic [LIMIT_BITS-1:0] LIMIT_MAX = '1;

   // smallest block log accepted
   localparam int LOG_BLOCK_MIN = 2;

   // register reset values
   localparam logic [LOG_FIELD_BITS-1:0] LOG_BLOCK_RST = 4'd10;
   localparam logic [GAIN_BITS-1:0]      GAIN_RST      = 8'd5;
   localparam logic [LAG_BITS-1:0]       LAG_RST       = 10'd0;

   // register indexes
   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_LOG_BLOCK  = 2'd0,
      CSR_SIGMA_GAIN = 2'd1,
      CSR_LAG        = 2'd2
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;      // capture the input item
      logic test;      // limit update, peak test, magnitude accumulate
      logic accum;     // square accumulate
      logic mean;      // block mean
      logic mult;      // mean squared and mean times sum
      logic plus;      // variance terms
      logic diff;      // variance
      logic root_go;   // start the square root
      logic gain;      // gain times sigma
      logic limit;     // new pending limit, clear block sums
   } atpd_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic block_end;
      logic root_done;
      logic rsp_busy;
   } atpd_status_type;

endpackage

// File: rtl/adaptive_threshold_peak_detect.sv
// ----------------------------------------------------------------------------
// adaptive_threshold_peak_detect
// Mean plus gain times sigma threshold detector over aligned sample blocks.
// ----------------------------------------------------------------------------
// Each sample passes through capture, test and magnitude sum, and square
// sum before the next one can be taken; a result is written to the output
// register by the test step, the step right after the capture. The sample
// that closes a block then runs the statistics and limit steps, which wait
// on the square root of the block variance, which resolves one root bit
// per cycle; ROOT_BITS is half of 2*SAMPLE_BITS + MAX_LOG_BLOCK, rounded
// up. A new item is also held off while an earlier result waits in the
// output register and is not taken.
// ----------------------------------------------------------------------------
module adaptive_threshold_peak_detect
   import atpd_pkg::*;
#(
   parameter int MAX_LOG_BLOCK = MAX_LOG_BLOCK_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF,
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8,
   localparam int RSP_DATA_BITS = ((POSITION_BITS + 2 * SAMPLE_BITS + 7) / 8) * 8
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration writes
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   // input items
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // sample
   input  logic                     req_tuser,   // restart
   // result items
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // position, peak_value, excess
);

   atpd_cmd_type             cmd;
   atpd_status_type          status;
   logic [POSITION_BITS-1:0] position;
   logic [SAMPLE_BITS-1:0]   peak_value;
   logic [SAMPLE_BITS-1:0]   excess;

   atpd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .req_tready (req_tready),
      .cmd        (cmd)
   );

   atpd_datapath #(
      .MAX_LOG_BLOCK (MAX_LOG_BLOCK),
      .SAMPLE_BITS   (SAMPLE_BITS),
      .POSITION_BITS (POSITION_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .req_sample     (req_tdata[SAMPLE_BITS-1:0]),
      .req_restart    (req_tuser),
      .rsp_tready     (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_position   (position),
      .rsp_peak_value (peak_value),
      .rsp_excess     (excess)
   );

   // result packing, position in the lowest bits
   assign rsp_tdata = RSP_DATA_BITS'({excess, peak_value, position});

`ifndef SYNTHESIS
   // one item in flight at a time
   a_single_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("item accepted while another is in work");

   // the test step directly follows the capture
   a_test_after_load: assert property (@(posedge clock) disable iff (reset)
      cmd.test |-> $past(cmd.load))
      else $error("test step without a captured item");

   // a waiting result holds off new items
   a_result_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item accepted while result slot is full");

   // block end starts the statistics sequence
   a_block_stats: assert property (@(posedge clock) disable iff (reset)
      cmd.accum && status.block_end |=> cmd.mean)
      else $error("block end did not start the statistics");
`endif

endmodule

// File: rtl/atpd_sqrt.sv
// ----------------------------------------------------------------------------
// atpd_sqrt
// Floor square root, one result bit per cycle.
// ----------------------------------------------------------------------------
module atpd_sqrt
   import atpd_pkg::*;
#(
   parameter int VALUE_BITS = 42,
   localparam int ROOT_BITS = (VALUE_BITS + 1) / 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VALUE_BITS-1:0] value,
   output logic                  done,
   output logic [ROOT_BITS-1:0]  root
);

   localparam int EVEN_BITS = 2 * ROOT_BITS;

   logic [EVEN_BITS-1:0] rem_ff, rem_in;
   logic [EVEN_BITS-1:0] root_ff, root_in;
   logic [EVEN_BITS-1:0] probe_ff, probe_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [EVEN_BITS:0]   trial;

   // one step of the digit-by-digit root
   always_comb begin
      trial    = {1'b0, root_ff} + {1'b0, probe_ff};
      rem_in   = rem_ff;
      root_in  = root_ff;
      probe_in = probe_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         rem_in   = EVEN_BITS'(value);
         root_in  = '0;
         probe_in = EVEN_BITS'(1) << (EVEN_BITS - 2);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if ({1'b0, rem_ff} >= trial) begin
            rem_in  = rem_ff - trial[EVEN_BITS-1:0];
            root_in = (root_ff >> 1) + probe_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         probe_in = probe_ff >> 2;
         // last step when the probe reaches the lowest bit
         if (probe_ff[0]) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      probe_ff <= probe_in;
   end

   assign done = done_ff;
   assign root = root_ff[ROOT_BITS-1:0];

endmodule

// File: rtl/atpd_datapath.sv
// ----------------------------------------------------------------------------
// atpd_datapath
// Configuration registers, block statistics, limit pipeline, peak test and
// the result register.
// ----------------------------------------------------------------------------
module atpd_datapath
   import atpd_pkg::*;
#(
   parameter int MAX_LOG_BLOCK = MAX_LOG_BLOCK_DEF,
   parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
   parameter int POSITION_BITS = POSITION_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  atpd_cmd_type             cmd,
   output atpd_status_type          status,
   input  logic                     csr_we,
   input  logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [SAMPLE_BITS-1:0]   req_sample,
   input  logic                     req_restart,
   input  logic                     rsp_tready,
   output logic                     rsp_valid,
   output logic [POSITION_BITS-1:0] rsp_position,
   output logic [SAMPLE_BITS-1:0]   rsp_peak_value,
   output logic [SAMPLE_BITS-1:0]   rsp_excess
);

   localparam int MAG_BITS  = SAMPLE_BITS;
   localparam int SUM_BITS  = SAMPLE_BITS + MAX_LOG_BLOCK;
   localparam int SQ_BITS   = 2 * SAMPLE_BITS - 1 + MAX_LOG_BLOCK;
   localparam int PLUS_BITS = SQ_BITS + 1;
   // a block cut short by a smaller log can carry a mean above one sample
   localparam int MEAN_BITS = SUM_BITS - LOG_BLOCK_MIN;
   localparam int SQP_BITS  = 2 * MAG_BITS;
   localparam int MSQ_BITS  = 2 * MEAN_BITS;
   localparam int MSUM_BITS = MEAN_BITS + SUM_BITS;
   localparam int WIDE_BITS = MSUM_BITS + 1;
   localparam int ROOT_BITS = (PLUS_BITS + 1) / 2;
   localparam int FILL_BITS = MAX_LOG_BLOCK + 1;
   localparam int LB_BITS   = $clog2(MAX_LOG_BLOCK + 1);
   localparam int CMP_BITS  = (LAG_BITS > FILL_BITS) ? LAG_BITS : FILL_BITS;
   localparam int GP_BITS   = GAIN_BITS + ROOT_BITS;
   localparam int LSUM_BITS = ((GP_BITS > MEAN_BITS) ? GP_BITS : MEAN_BITS) + 1;
   localparam int SAT_BITS  = (LSUM_BITS > LIMIT_BITS) ? LSUM_BITS : LIMIT_BITS;
   localparam int TST_BITS  = (MAG_BITS > LIMIT_BITS) ? MAG_BITS : LIMIT_BITS;

   // configuration
   logic [LOG_FIELD_BITS-1:0] log_ff, log_in;
   logic [GAIN_BITS-1:0]      gain_ff, gain_in;
   logic [LAG_BITS-1:0]       lag_ff, lag_in;

   // running state
   logic [POSITION_BITS-1:0]  pos_ff, pos_in;
   logic [FILL_BITS-1:0]      fill_ff, fill_in;
   logic [SUM_BITS-1:0]       sum_ff, sum_in;
   logic [SQ_BITS-1:0]        sq_ff, sq_in;
   logic [LIMIT_BITS-1:0]     al_ff, al_in;
   logic                      av_ff, av_in;
   logic [LIMIT_BITS-1:0]     pl_ff, pl_in;
   logic [LAG_BITS-1:0]       pc_ff, pc_in;
   logic                      pv_ff, pv_in;
   logic                      block_end_ff, block_end_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // item and pipeline payload
   logic [SAMPLE_BITS-1:0]    raw_ff, raw_in;
   logic [MAG_BITS-1:0]       mag_ff, mag_in;
   logic                      restart_ff, restart_in;
   logic [SQP_BITS-1:0]       sqp_ff, sqp_in;
   logic [MEAN_BITS-1:0]      mean_ff, mean_in;
   logic [MSQ_BITS-1:0]       msq_ff, msq_in;
   logic [MSUM_BITS-1:0]      msum_ff, msum_in;
   logic [WIDE_BITS-1:0]      plus_ff, plus_in;
   logic [WIDE_BITS-1:0]      minus_ff, minus_in;
   logic [PLUS_BITS-1:0]      var_ff, var_in;
   logic [GP_BITS-1:0]        gprod_ff, gprod_in;
   logic [POSITION_BITS-1:0]  rpos_ff, rpos_in;
   logic [SAMPLE_BITS-1:0]    rpeak_ff, rpeak_in;
   logic [SAMPLE_BITS-1:0]    rexc_ff, rexc_in;

   // combinational helpers
   logic [LB_BITS-1:0]        lb;
   logic [FILL_BITS-1:0]      blen;
   logic [CMP_BITS-1:0]       lag_ext;
   logic [CMP_BITS-1:0]       last_ext;
   logic [POSITION_BITS-1:0]  pos_base;
   logic [FILL_BITS-1:0]      fill_next;
   logic [SUM_BITS-1:0]       sum_base;
   logic                      av_new;
   logic [LIMIT_BITS-1:0]     al_new;
   logic                      pv_new;
   logic [LAG_BITS-1:0]       pc_new;
   logic                      hit;
   logic [TST_BITS-1:0]       over;
   logic [MSUM_BITS-1:0]      msum_full;
   logic [WIDE_BITS-1:0]      diff;
   logic [LSUM_BITS-1:0]      lsum;
   logic                      root_done;
   logic [ROOT_BITS-1:0]      sigma;

   // effective block log and block length
   always_comb begin
      if (int'(log_ff) < LOG_BLOCK_MIN) begin
         lb = LB_BITS'(LOG_BLOCK_MIN);
      end else if (int'(log_ff) > MAX_LOG_BLOCK) begin
         lb = LB_BITS'(MAX_LOG_BLOCK);
      end else begin
         lb = LB_BITS'(log_ff);
      end
      blen     = FILL_BITS'(1) << lb;
      lag_ext  = CMP_BITS'(lag_ff);
      last_ext = CMP_BITS'(blen - FILL_BITS'(1));
   end

   // square root unit
   atpd_sqrt #(
      .VALUE_BITS (PLUS_BITS)
   ) u_sqrt (
      .clock (clock),
      .reset (reset),
      .start (cmd.root_go),
      .value (var_ff),
      .done  (root_done),
      .root  (sigma)
   );

   // per-sample view of the state after a restart and the pending step
   always_comb begin
      pos_base = restart_ff ? '0 : pos_ff;
      sum_base = restart_ff ? '0 : sum_ff;
      fill_next = (restart_ff ? '0 : fill_ff) + FILL_BITS'(1);
      av_new = restart_ff ? 1'b0 : av_ff;
      al_new = restart_ff ? '0 : al_ff;
      pv_new = restart_ff ? 1'b0 : pv_ff;
      pc_new = pc_ff;
      if (pv_new) begin
         if (pc_ff == '0) begin
            al_new = pl_ff;
            av_new = 1'b1;
            pv_new = 1'b0;
         end else begin
            pc_new = pc_ff - LAG_BITS'(1);
         end
      end
      hit  = av_new && (TST_BITS'(mag_ff) > TST_BITS'(al_new));
      over = TST_BITS'(mag_ff) - TST_BITS'(al_new);
      msum_full = mean_ff * sum_ff;
      diff = plus_ff - minus_ff;
      lsum = LSUM_BITS'(mean_ff) + LSUM_BITS'(gprod_ff);
   end

   // next values
   always_comb begin
      log_in       = log_ff;
      gain_in      = gain_ff;
      lag_in       = lag_ff;
      pos_in       = pos_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      al_in        = al_ff;
      av_in        = av_ff;
      pl_in        = pl_ff;
      pc_in        = pc_ff;
      pv_in        = pv_ff;
      block_end_in = block_end_ff;
      rsp_valid_in = rsp_valid_ff;
      raw_in       = raw_ff;
      mag_in       = mag_ff;
      restart_in   = restart_ff;
      sqp_in       = sqp_ff;
      mean_in      = mean_ff;
      msq_in       = msq_ff;
      msum_in      = msum_ff;
      plus_in      = plus_ff;
      minus_in     = minus_ff;
      var_in       = var_ff;
      gprod_in     = gprod_ff;
      rpos_in      = rpos_ff;
      rpeak_in     = rpeak_ff;
      rexc_in      = rexc_ff;

      // register writes
      if (csr_we) begin
         case (csr_addr)
            CSR_LOG_BLOCK:  log_in  = csr_wdata[LOG_FIELD_BITS-1:0];
            CSR_SIGMA_GAIN: gain_in = csr_wdata[GAIN_BITS-1:0];
            CSR_LAG:        lag_in  = csr_wdata[LAG_BITS-1:0];
            default: ;
         endcase
      end

      // result handed over
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // capture item, magnitude of the sample
      if (cmd.load) begin
         raw_in     = req_sample;
         mag_in     = req_sample[SAMPLE_BITS-1] ? (MAG_BITS'(0) - req_sample) : req_sample;
         restart_in = req_restart;
      end

      // limit update, peak test, magnitude sum
      if (cmd.test) begin
         pos_in       = pos_base + POSITION_BITS'(1);
         av_in        = av_new;
         al_in        = al_new;
         pv_in        = pv_new;
         pc_in        = pc_new;
         sum_in       = sum_base + SUM_BITS'(mag_ff);
         fill_in      = fill_next;
         block_end_in = fill_next >= blen;
         sqp_in       = mag_ff * mag_ff;
         if (restart_ff) begin
            sq_in = '0;
         end
         if (hit) begin
            rsp_valid_in = 1'b1;
            rpos_in      = pos_base;
            rpeak_in     = raw_ff;
            rexc_in      = over[SAMPLE_BITS-1:0];
         end
      end

      // square sum
      if (cmd.accum) begin
         sq_in = sq_ff + SQ_BITS'(sqp_ff);
      end

      // block statistics
      if (cmd.mean) begin
         mean_in = MEAN_BITS'(sum_ff >> lb);
      end
      if (cmd.mult) begin
         msq_in  = mean_ff * mean_ff;
         msum_in = msum_full;
      end
      // mean squared times block length never exceeds mean times sum
      if (cmd.plus) begin
         plus_in  = WIDE_BITS'(sq_ff) + (WIDE_BITS'(msq_ff) << lb);
         minus_in = {msum_ff, 1'b0};
      end
      // the difference never exceeds the square sum
      if (cmd.diff) begin
         var_in = (plus_ff > minus_ff) ? PLUS_BITS'(diff >> lb) : '0;
      end
      if (cmd.gain) begin
         gprod_in = gain_ff * sigma;
      end

      // new pending limit with saturated lag, block restarts
      if (cmd.limit) begin
         if (SAT_BITS'(lsum) > SAT_BITS'(LIMIT_MAX)) begin
            pl_in = LIMIT_MAX;
         end else begin
            pl_in = LIMIT_BITS'(lsum);
         end
         pc_in   = (lag_ext > last_ext) ? LAG_BITS'(last_ext) : lag_ff;
         pv_in   = 1'b1;
         fill_in = '0;
         sum_in  = '0;
         sq_in   = '0;
      end
   end

   // state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         log_ff       <= LOG_BLOCK_RST;
         gain_ff      <= GAIN_RST;
         lag_ff       <= LAG_RST;
         pos_ff       <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         al_ff        <= '0;
         av_ff        <= 1'b0;
         pl_ff        <= '0;
         pc_ff        <= '0;
         pv_ff        <= 1'b0;
         block_end_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         log_ff       <= log_in;
         gain_ff      <= gain_in;
         lag_ff       <= lag_in;
         pos_ff       <= pos_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         al_ff        <= al_in;
         av_ff        <= av_in;
         pl_ff        <= pl_in;
         pc_ff        <= pc_in;
         pv_ff        <= pv_in;
         block_end_ff <= block_end_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      raw_ff     <= raw_in;
      mag_ff     <= mag_in;
      restart_ff <= restart_in;
      sqp_ff     <= sqp_in;
      mean_ff    <= mean_in;
      msq_ff     <= msq_in;
      msum_ff    <= msum_in;
      plus_ff    <= plus_in;
      minus_ff   <= minus_in;
      var_ff     <= var_in;
      gprod_ff   <= gprod_in;
      rpos_ff    <= rpos_in;
      rpeak_ff   <= rpeak_in;
      rexc_ff    <= rexc_in;
   end

   assign status.block_end = block_end_ff;
   assign status.root_done = root_done;
   assign status.rsp_busy  = rsp_valid_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_position   = rpos_ff;
   assign rsp_peak_value = rpeak_ff;
   assign rsp_excess     = rexc_ff;

endmodule

// File: rtl/atpd_ctrl.sv
// ----------------------------------------------------------------------------
// atpd_ctrl
// Sequencer: takes one item, runs the sample step and, at block end, the
// statistics and limit steps.
// ----------------------------------------------------------------------------
module atpd_ctrl
   import atpd_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   input  logic            rsp_tready,
   input  atpd_status_type status,
   output logic            req_tready,
   output atpd_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_TEST,
      S_ACCUM,
      S_MEAN,
      S_MULT,
      S_PLUS,
      S_DIFF,
      S_ROOT_GO,
      S_ROOT,
      S_GAIN,
      S_LIMIT
   } state_type;

   state_type state_ff, state_in;

   // ready while idle and the result slot is free or draining
   assign req_tready = (state_ff == S_IDLE) && (!status.rsp_busy || rsp_tready);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_tvalid && req_tready) state_in = S_TEST;
         S_TEST:    state_in = S_ACCUM;
         S_ACCUM:   state_in = status.block_end ? S_MEAN : S_IDLE;
         S_MEAN:    state_in = S_MULT;
         S_MULT:    state_in = S_PLUS;
         S_PLUS:    state_in = S_DIFF;
         S_DIFF:    state_in = S_ROOT_GO;
         S_ROOT_GO: state_in = S_ROOT;
         S_ROOT:    if (status.root_done) state_in = S_GAIN;
         S_GAIN:    state_in = S_LIMIT;
         S_LIMIT:   state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   // command decode
   always_comb begin
      cmd         = '0;
      cmd.load    = (state_ff == S_IDLE) && req_tvalid && req_tready;
      cmd.test    = (state_ff == S_TEST);
      cmd.accum   = (state_ff == S_ACCUM);
      cmd.mean    = (state_ff == S_MEAN);
      cmd.mult    = (state_ff == S_MULT);
      cmd.plus    = (state_ff == S_PLUS);
      cmd.diff    = (state_ff == S_DIFF);
      cmd.root_go = (state_ff == S_ROOT_GO);
      cmd.gain    = (state_ff == S_GAIN);
      cmd.limit   = (state_ff == S_LIMIT);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
